// ----- sv/slcfp_pkg.sv -----
// Shared types and constants for the sync/length/checksum frame parser.
// Used by slcfp_store and sync_length_checksum_frame_parser; no dependencies.
`default_nettype none

package slcfp_pkg;

    localparam logic [7:0] SYNC_A      = 8'hAA;
    localparam logic [7:0] SYNC_B      = 8'h55;
    localparam int         STORE_DEPTH = 64;
    localparam int         ADDR_W      = $clog2(STORE_DEPTH);
    localparam int         LEN_W       = ADDR_W + 1;
    localparam int         MAX_LEN     = 64;
    // Longest length field that is taken; anything above drops the frame.
    localparam int         LEN_LIMIT   = (MAX_LEN < STORE_DEPTH) ? MAX_LEN : STORE_DEPTH;

    typedef enum logic [2:0] {
        PH_HDR1,
        PH_HDR2,
        PH_LEN,
        PH_DATA,
        PH_SUM,
        PH_READ
    } t_phase;

    typedef enum logic [1:0] {
        ST_DATA    = 2'd0,
        ST_EMPTY   = 2'd1,
        ST_CRC_ERR = 2'd2
    } t_status;

endpackage

`default_nettype wire

// ----- sv/sync_length_checksum_frame_parser.sv -----
// Top level of the frame parser: header/length/checksum state machine,
// payload readout sequencer and output register. Depends on slcfp_pkg, slcfp_store.
//
// Usage:
//   Input channel (i_in_valid / o_in_ready / i_in_byte) takes one received byte
//   per beat. Frames are 0xAA, 0x55, length, payload, checksum. Header, length
//   and payload bytes are taken one per cycle; payload bytes go into a 64-entry
//   RAM while the additive checksum runs.
//   Output channel (o_out_valid / i_out_ready) carries result beats from a
//   register. A good frame of length N gives N beats, read back from the RAM
//   at one per cycle while the receiver is ready; the first beat passes the
//   phase register, the RAM read and the output register after the checksum
//   byte, and last marks the final beat. An empty frame or a checksum error
//   gives one beat, in the cycle after the checksum byte. The input is held
//   off during the readout, and the checksum byte waits until earlier results
//   have left the output register. A frame of N bytes thus takes N + 4 input
//   beats, then the readout. A stalled receiver stops the readout; nothing is dropped.
//   Reset returns the parser to the header search and empties the output;
//   the RAM is not cleared, as only entries of the current frame are read.
`default_nettype none

module sync_length_checksum_frame_parser
    import slcfp_pkg::*;
(
    input  wire logic        i_clk,
    input  wire logic        i_rst_n,
    input  wire logic        i_in_valid,
    output logic             o_in_ready,
    input  wire logic [7:0]  i_in_byte,
    output logic             o_out_valid,
    input  wire logic        i_out_ready,
    output logic [1:0]       o_status,
    output logic [7:0]       o_payload_byte,
    output logic [5:0]       o_byte_index,
    output logic [6:0]       o_packet_length,
    output logic             o_last
);

    t_phase             r_phase, n_phase;
    logic [LEN_W-1:0]   r_len, n_len;
    logic [LEN_W-1:0]   r_fill, n_fill;
    logic [7:0]         r_sum, n_sum;
    logic [ADDR_W-1:0]  r_rd_idx, n_rd_idx;
    logic               r_pend, n_pend;
    logic [ADDR_W-1:0]  r_pend_idx;
    logic               r_pend_last;
    logic [LEN_W-1:0]   r_pend_len;
    logic               r_out_valid;
    t_status            r_status;
    logic [7:0]         r_payload;
    logic [ADDR_W-1:0]  r_index;
    logic [LEN_W-1:0]   r_plen;
    logic               r_last;

    logic               in_acc;
    logic               wr_en;
    logic               rd_issue;
    logic               rd_last;
    logic               move;
    logic               load_sum;
    logic               sum_bad;
    logic [LEN_W-1:0]   fill_inc;
    logic [7:0]         rd_data;

    slcfp_store u_store (
        .i_clk     (i_clk),
        .i_wr_en   (wr_en),
        .i_wr_addr (r_fill[ADDR_W-1:0]),
        .i_wr_data (i_in_byte),
        .i_rd_en   (rd_issue),
        .i_rd_addr (r_rd_idx),
        .o_rd_data (rd_data)
    );

    assign in_acc   = i_in_valid && o_in_ready;
    assign fill_inc = r_fill + LEN_W'(1);
    assign sum_bad  = (r_sum != i_in_byte);
    assign rd_last  = ({1'b0, r_rd_idx} == (r_len - LEN_W'(1)));
    assign move     = r_pend && (!r_out_valid || i_out_ready);

    // Next phase.
    always_comb begin
        n_phase = r_phase;
        unique case (r_phase)
            PH_HDR1: begin
                if (in_acc) begin
                    n_phase = (i_in_byte == SYNC_A) ? PH_HDR2 : PH_HDR1;
                end
            end
            PH_HDR2: begin
                if (in_acc) begin
                    n_phase = (i_in_byte == SYNC_B) ? PH_LEN : PH_HDR1;
                end
            end
            PH_LEN: begin
                if (in_acc) begin
                    if (i_in_byte > 8'(LEN_LIMIT)) begin
                        n_phase = PH_HDR1;
                    end else if (i_in_byte == 8'd0) begin
                        n_phase = PH_SUM;
                    end else begin
                        n_phase = PH_DATA;
                    end
                end
            end
            PH_DATA: begin
                if (in_acc && (fill_inc >= r_len)) begin
                    n_phase = PH_SUM;
                end
            end
            PH_SUM: begin
                if (in_acc) begin
                    n_phase = (sum_bad || (r_len == '0)) ? PH_HDR1 : PH_READ;
                end
            end
            PH_READ: begin
                if (rd_issue && rd_last) begin
                    n_phase = PH_HDR1;
                end
            end
            default: n_phase = PH_HDR1;
        endcase
    end

    // Handshake, RAM control and datapath next values.
    always_comb begin
        o_in_ready = 1'b1;
        wr_en      = 1'b0;
        rd_issue   = 1'b0;
        load_sum   = 1'b0;
        n_len      = r_len;
        n_fill     = r_fill;
        n_sum      = r_sum;
        n_rd_idx   = r_rd_idx;
        unique case (r_phase) inside
            PH_HDR1, PH_HDR2: begin
                if (in_acc) begin
                    n_len  = '0;
                    n_fill = '0;
                    n_sum  = '0;
                end
            end
            PH_LEN: begin
                if (in_acc) begin
                    if (i_in_byte > 8'(LEN_LIMIT)) begin
                        n_len = '0;
                        n_sum = '0;
                    end else begin
                        n_len = i_in_byte[LEN_W-1:0];
                        n_sum = SYNC_A + SYNC_B + i_in_byte;
                    end
                    n_fill = '0;
                end
            end
            PH_DATA: begin
                if (in_acc) begin
                    wr_en  = 1'b1;
                    n_sum  = r_sum + i_in_byte;
                    n_fill = fill_inc;
                end
            end
            PH_SUM: begin
                // The checksum byte waits until all earlier results have left.
                o_in_ready = !r_pend && (!r_out_valid || i_out_ready);
                if (in_acc) begin
                    load_sum = sum_bad || (r_len == '0);
                    n_rd_idx = '0;
                    if (load_sum) begin
                        n_len  = '0;
                        n_fill = '0;
                        n_sum  = '0;
                    end
                end
            end
            PH_READ: begin
                o_in_ready = 1'b0;
                // A read may be issued when the RAM output is free or being moved on.
                rd_issue   = !r_pend || move;
                if (rd_issue) begin
                    n_rd_idx = r_rd_idx + ADDR_W'(1);
                    if (rd_last) begin
                        n_fill = '0;
                        n_sum  = '0;
                    end
                end
            end
            default: o_in_ready = 1'b1;
        endcase
        if (rd_issue) begin
            n_pend = 1'b1;
        end else if (move) begin
            n_pend = 1'b0;
        end else begin
            n_pend = r_pend;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_phase     <= PH_HDR1;
            r_len       <= '0;
            r_fill      <= '0;
            r_sum       <= '0;
            r_rd_idx    <= '0;
            r_pend      <= 1'b0;
            r_out_valid <= 1'b0;
        end else begin
            r_phase  <= n_phase;
            r_len    <= n_len;
            r_fill   <= n_fill;
            r_sum    <= n_sum;
            r_rd_idx <= n_rd_idx;
            r_pend   <= n_pend;
            if (move || load_sum) begin
                r_out_valid <= 1'b1;
            end else if (i_out_ready) begin
                r_out_valid <= 1'b0;
            end
        end
    end

    // Payload of the output register and of the read in flight. The length
    // travels with the read, since the next frame may already be arriving.
    always_ff @(posedge i_clk) begin
        if (rd_issue) begin
            r_pend_idx  <= r_rd_idx;
            r_pend_last <= rd_last;
            r_pend_len  <= r_len;
        end
        if (move) begin
            r_status  <= ST_DATA;
            r_payload <= rd_data;
            r_index   <= r_pend_idx;
            r_plen    <= r_pend_len;
            r_last    <= r_pend_last;
        end else if (load_sum) begin
            r_status  <= sum_bad ? ST_CRC_ERR : ST_EMPTY;
            r_payload <= '0;
            r_index   <= '0;
            r_plen    <= sum_bad ? r_len : '0;
            r_last    <= 1'b1;
        end
    end

    assign o_out_valid     = r_out_valid;
    assign o_status        = r_status;
    assign o_payload_byte  = r_payload;
    assign o_byte_index    = r_index;
    assign o_packet_length = r_plen;
    assign o_last          = r_last;

endmodule

`default_nettype wire

// ----- sv/slcfp_store.sv -----
// Payload store: 64 x 8 synchronous RAM, one write and one read port.
// Read data is registered and holds while no read is issued.
// Depends on slcfp_pkg.
`default_nettype none

module slcfp_store
    import slcfp_pkg::*;
(
    input  wire logic              i_clk,
    input  wire logic              i_wr_en,
    input  wire logic [ADDR_W-1:0] i_wr_addr,
    input  wire logic [7:0]        i_wr_data,
    input  wire logic              i_rd_en,
    input  wire logic [ADDR_W-1:0] i_rd_addr,
    output logic      [7:0]        o_rd_data
);

    logic [7:0] r_mem [STORE_DEPTH];

    always_ff @(posedge i_clk) begin
        if (i_wr_en) begin
            r_mem[i_wr_addr] <= i_wr_data;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_rd_en) begin
            o_rd_data <= r_mem[i_rd_addr];
        end
    end

endmodule

`default_nettype wire
